>>> rtl/tttd_pkg.sv
// Package: widths, register codes, reset values and shared types of the two-tone detector.
`timescale 1ns / 1ps

package tttd_pkg;

	localparam int TIME_W  = 32;
	localparam int LEVEL_W = 20;
	localparam int MS_W    = 16;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 20;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_LEVEL_THRESHOLD = 3'd0;
	localparam logic [CIDX_W-1:0] REG_TONE1_MIN_MS    = 3'd1;
	localparam logic [CIDX_W-1:0] REG_TONE2_MIN_MS    = 3'd2;
	localparam logic [CIDX_W-1:0] REG_GAP_WINDOW_MS   = 3'd3;
	localparam logic [CIDX_W-1:0] REG_HOLD_OFF_MS     = 3'd4;

	// register reset values
	localparam logic [LEVEL_W-1:0] RST_LEVEL_THRESHOLD = 20'd5000;
	localparam logic [MS_W-1:0]    RST_TONE1_MIN_MS    = 16'd500;
	localparam logic [MS_W-1:0]    RST_TONE2_MIN_MS    = 16'd700;
	localparam logic [MS_W-1:0]    RST_GAP_WINDOW_MS   = 16'd2000;
	localparam logic [MS_W-1:0]    RST_HOLD_OFF_MS     = 16'd2000;

	typedef struct packed {
		logic [LEVEL_W-1:0] level_threshold;
		logic [MS_W-1:0]    tone1_min_ms;
		logic [MS_W-1:0]    tone2_min_ms;
		logic [MS_W-1:0]    gap_window_ms;
		logic [MS_W-1:0]    hold_off_ms;
	} cfg_t;

	// one tone track: start time (zero = not started) and active flag
	typedef struct packed {
		logic [TIME_W-1:0] start;
		logic              flag;
	} track_t;

endpackage

>>> rtl/tttd_ifs.sv
// Interfaces: item, result and configuration write channels.
`timescale 1ns / 1ps

interface tttd_item_if;
	logic                        valid;
	logic                        ready;
	logic [tttd_pkg::TIME_W-1:0]  now_ms;
	logic                        tone1_peak;
	logic [tttd_pkg::LEVEL_W-1:0] tone1_level;
	logic                        tone2_peak;
	logic [tttd_pkg::LEVEL_W-1:0] tone2_level;

	modport source (output valid, now_ms, tone1_peak, tone1_level, tone2_peak, tone2_level,
		input ready);
	modport sink (input valid, now_ms, tone1_peak, tone1_level, tone2_peak, tone2_level,
		output ready);
endinterface

interface tttd_result_if;
	logic valid;
	logic ready;
	logic detect_pulse;
	logic tone1_on;
	logic tone2_on;
	logic holding;
	logic cleared;

	modport source (output valid, detect_pulse, tone1_on, tone2_on, holding, cleared,
		input ready);
	modport sink (input valid, detect_pulse, tone1_on, tone2_on, holding, cleared,
		output ready);
endinterface

interface tttd_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [tttd_pkg::CIDX_W-1:0]  index;
	logic [tttd_pkg::CDATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/tttd_cfg_regs.sv
// Configuration register file, written through the config channel.
`timescale 1ns / 1ps

module tttd_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	tttd_cfg_if.sink       cfg,
	output tttd_pkg::cfg_t regs
);

	tttd_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.level_threshold <= tttd_pkg::RST_LEVEL_THRESHOLD;
			regs_q.tone1_min_ms    <= tttd_pkg::RST_TONE1_MIN_MS;
			regs_q.tone2_min_ms    <= tttd_pkg::RST_TONE2_MIN_MS;
			regs_q.gap_window_ms   <= tttd_pkg::RST_GAP_WINDOW_MS;
			regs_q.hold_off_ms     <= tttd_pkg::RST_HOLD_OFF_MS;
		end else if (cfg.valid) begin
			// out-of-range index: dropped
			unique case (cfg.index)
				tttd_pkg::REG_LEVEL_THRESHOLD:
					regs_q.level_threshold <= cfg.data[tttd_pkg::LEVEL_W-1:0];
				tttd_pkg::REG_TONE1_MIN_MS:
					regs_q.tone1_min_ms <= cfg.data[tttd_pkg::MS_W-1:0];
				tttd_pkg::REG_TONE2_MIN_MS:
					regs_q.tone2_min_ms <= cfg.data[tttd_pkg::MS_W-1:0];
				tttd_pkg::REG_GAP_WINDOW_MS:
					regs_q.gap_window_ms <= cfg.data[tttd_pkg::MS_W-1:0];
				tttd_pkg::REG_HOLD_OFF_MS:
					regs_q.hold_off_ms <= cfg.data[tttd_pkg::MS_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

>>> rtl/tttd_tone_track.sv
// Next-state logic of one tone track.
`timescale 1ns / 1ps

module tttd_tone_track (
	input  logic [tttd_pkg::TIME_W-1:0] now_ms,
	input  logic                        present,
	input  logic [tttd_pkg::MS_W-1:0]   min_ms,
	input  logic [tttd_pkg::MS_W-1:0]   gap_ms,
	input  tttd_pkg::track_t            cur,
	output tttd_pkg::track_t            nxt
);

	logic [tttd_pkg::TIME_W-1:0] elapsed;

	// modulo 2^32 elapsed time
	assign elapsed = now_ms - cur.start;

	always_comb begin
		nxt = cur;
		if (present) begin
			if (cur.start == '0) begin
				nxt.start = now_ms;
			end else if (elapsed >= tttd_pkg::TIME_W'(min_ms)) begin
				nxt.flag = 1'b1;
			end
		end else if (elapsed > tttd_pkg::TIME_W'(gap_ms)) begin
			nxt.start = '0;
			nxt.flag  = 1'b0;
		end
	end

endmodule

>>> rtl/two_tone_sequence_detector.sv
// Top level of the two-tone sequence detector: input stage, state and result register.
`timescale 1ns / 1ps

// channel  modport  payload                                                  transaction
// item     sink     now_ms, tone1_peak, tone1_level, tone2_peak, tone2_level  valid & ready
// result   source   detect_pulse, tone1_on, tone2_on, holding, cleared       valid & ready
// cfg      sink     index, data (register i at index i)                      valid & ready
//
// One item per cycle sustained while the result channel is ready. An item waits in the
// input register, where the tone tracks and cooldown logic evaluate it against the state
// registers; its result is then registered in the result register when the stage moves on.
// Reset (arst_n low) clears the tracks and cooldown end and restores register defaults.
// A stalled result holds the input stage; the item channel still takes a transaction
// whenever the input register is empty or moving on in the same cycle.

module two_tone_sequence_detector (
	input  logic          clk,
	input  logic          arst_n,
	tttd_item_if.sink     item,
	tttd_result_if.source result,
	tttd_cfg_if.sink      cfg
);

	tttd_pkg::cfg_t regs;

	tttd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// ---------------- input stage ----------------
	logic                         valid_s1;
	logic [tttd_pkg::TIME_W-1:0]  now_s1;
	logic                         peak1_s1;
	logic [tttd_pkg::LEVEL_W-1:0] level1_s1;
	logic                         peak2_s1;
	logic [tttd_pkg::LEVEL_W-1:0] level2_s1;

	logic advance;

	// the input stage moves on when the result register is free or being emptied
	assign advance    = valid_s1 && (!result.valid || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			now_s1    <= item.now_ms;
			peak1_s1  <= item.tone1_peak;
			level1_s1 <= item.tone1_level;
			peak2_s1  <= item.tone2_peak;
			level2_s1 <= item.tone2_level;
		end
	end

	// ---------------- state ----------------
	tttd_pkg::track_t            trk1_q, trk2_q;
	logic [tttd_pkg::TIME_W-1:0] cool_end_q;

	tttd_pkg::track_t            trk1_nx, trk2_nx;
	tttd_pkg::track_t            trk1_n, trk2_n;
	logic [tttd_pkg::TIME_W-1:0] cool_mid, cool_end_n;
	logic                        both_on, expired, clr, hold, fire;
	logic                        present1, present2;

	assign present1 = peak1_s1 && (level1_s1 > regs.level_threshold);
	assign present2 = peak2_s1 && (level2_s1 > regs.level_threshold);

	tttd_tone_track u_trk1 (
		.now_ms  (now_s1),
		.present (present1),
		.min_ms  (regs.tone1_min_ms),
		.gap_ms  (regs.gap_window_ms),
		.cur     (trk1_q),
		.nxt     (trk1_nx)
	);

	tttd_tone_track u_trk2 (
		.now_ms  (now_s1),
		.present (present2),
		.min_ms  (regs.tone2_min_ms),
		.gap_ms  (regs.gap_window_ms),
		.cur     (trk2_q),
		.nxt     (trk2_nx)
	);

	// both active: skip track update; clear all once now passes cooldown end
	assign both_on = trk1_q.flag && trk2_q.flag;
	assign expired = now_s1 > cool_end_q;
	assign clr     = both_on && expired;
	assign hold    = both_on && !expired;

	always_comb begin
		if (clr) begin
			trk1_n   = '0;
			trk2_n   = '0;
			cool_mid = '0;
		end else if (hold) begin
			trk1_n   = trk1_q;
			trk2_n   = trk2_q;
			cool_mid = cool_end_q;
		end else begin
			trk1_n   = trk1_nx;
			trk2_n   = trk2_nx;
			cool_mid = cool_end_q;
		end
	end

	// detection on the updated state; at now == cooldown end it fires again
	assign fire       = (now_s1 >= cool_mid) && trk1_n.flag && trk2_n.flag;
	assign cool_end_n = fire ? (now_s1 + tttd_pkg::TIME_W'(regs.hold_off_ms)) : cool_mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk1_q     <= '0;
			trk2_q     <= '0;
			cool_end_q <= '0;
		end else if (advance) begin
			trk1_q     <= trk1_n;
			trk2_q     <= trk2_n;
			cool_end_q <= cool_end_n;
		end
	end

	// ---------------- result register ----------------
	logic res_valid_q;
	logic pulse_q, on1_q, on2_q, holding_q, cleared_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pulse_q   <= fire;
			on1_q     <= trk1_n.flag;
			on2_q     <= trk2_n.flag;
			holding_q <= hold;
			cleared_q <= clr;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.detect_pulse = pulse_q;
	assign result.tone1_on     = on1_q;
	assign result.tone2_on     = on2_q;
	assign result.holding      = holding_q;
	assign result.cleared      = cleared_q;

	// ---------------- assertions ----------------
	// a clear leaves no track active, so no pulse can follow in the same step
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && cleared_q |-> !pulse_q && !on1_q && !on2_q)
		else $error("clear step reports active track or pulse");

	// holding only while both tracks stay active
	a_hold_both: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && holding_q |-> on1_q && on2_q && !cleared_q)
		else $error("holding without both tracks active");

	// state only moves with an item that passes to the result register
	a_state_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(cool_end_q) && $stable(trk1_q) && $stable(trk2_q))
		else $error("state changed without an item");

	// an empty input stage always takes a transaction
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item.ready)
		else $error("input stage empty but not ready");

	// a fired pulse pushes the cooldown end to now plus hold-off
	a_cool_set: assert property (@(posedge clk) disable iff (!arst_n)
		advance && fire |=>
			cool_end_q == $past(now_s1) + tttd_pkg::TIME_W'($past(regs.hold_off_ms)))
		else $error("cooldown end not set on detection");

endmodule

>>> tb/sv/tb_two_tone_sequence_detector.sv
// Self-checking testbench of the two-tone sequence detector: directed and random items.
`timescale 1ns / 1ps

// Stimulus is a queue of tone items. An initial block fills it one phase at a time and
// writes the registers between phases while the block is idle. A driver at the falling
// edge takes items from the queue, and a monitor at the rising edge works out the expected
// flags of every accepted item and checks them against the result transactions in order.
// Both handshakes stall at random, except over a stretch of items that runs with no gaps.

module tb_two_tone_sequence_detector;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 82;
	localparam int IDLE_PCT    = 35;
	// items sent in this range go out with no idling on either side
	localparam int CALM_FIRST  = 300;
	localparam int CALM_LAST   = 420;
	// first index past the register list; writes there must change nothing
	localparam logic [tttd_pkg::CIDX_W-1:0] REG_NONE_FIRST =
		tttd_pkg::REG_HOLD_OFF_MS + 3'd1;

	typedef struct packed {
		logic [tttd_pkg::TIME_W-1:0]  now_ms;
		logic                         tone1_peak;
		logic [tttd_pkg::LEVEL_W-1:0] tone1_level;
		logic                         tone2_peak;
		logic [tttd_pkg::LEVEL_W-1:0] tone2_level;
	} tone_item_t;

	typedef struct packed {
		logic detect_pulse;
		logic tone1_on;
		logic tone2_on;
		logic holding;
		logic cleared;
	} tone_flags_t;

	// register settings used for the phases
	typedef enum {CFG_ZERO, CFG_MAX, CFG_SHORT, CFG_LONG} cfg_style_t;

	logic clk;
	logic arst_n;

	tttd_item_if   item_ch ();
	tttd_result_if result_ch ();
	tttd_cfg_if    cfg_ch ();

	two_tone_sequence_detector dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// predictor state: register copy, both tone tracks and the cooldown end
	tttd_pkg::cfg_t              shadow_cfg;
	tttd_pkg::track_t            trk1;
	tttd_pkg::track_t            trk2;
	logic [tttd_pkg::TIME_W-1:0] cooldown_end;

	tone_item_t  tone_items[$];      // items waiting for the driver
	tone_flags_t predicted_flags[$]; // expected flags, oldest first

	logic item_fire = 1'b0;          // item transaction at the last rising edge
	int   sent_cnt = 0;
	int   mismatches = 0;
	int   cycles = 0;
	logic calm;

	assign calm = (sent_cnt >= CALM_FIRST) && (sent_cnt < CALM_LAST);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	// One tone track. The time since start is taken modulo 2^32, so a track that
	// started just before the timestamp wrapped still ages correctly.
	function automatic tttd_pkg::track_t advance_track(tttd_pkg::track_t tr,
		logic [tttd_pkg::TIME_W-1:0] now, logic present, logic [tttd_pkg::MS_W-1:0] min_ms);
		logic [tttd_pkg::TIME_W-1:0] age;
		age = now - tr.start;
		if (present) begin
			// a start of zero reads as "not started", also when now is zero
			if (tr.start == '0)
				tr.start = now;
			else if (age >= min_ms)
				tr.flag = 1'b1;
		end else if (age > shadow_cfg.gap_window_ms) begin
			tr.start = '0;
			tr.flag  = 1'b0;
		end
		return tr;
	endfunction

	// Expected flags of one item; updates the predictor state.
	function automatic tone_flags_t detect_step(tone_item_t it);
		tone_flags_t r;
		logic hear1;
		logic hear2;
		r = '0;
		if (trk1.flag && trk2.flag) begin
			// both active: tracks frozen until the time is strictly past the cooldown end
			if (it.now_ms > cooldown_end) begin
				trk1         = '0;
				trk2         = '0;
				cooldown_end = '0;
				r.cleared    = 1'b1;
			end else begin
				r.holding = 1'b1;
			end
		end else begin
			hear1 = it.tone1_peak && (it.tone1_level > shadow_cfg.level_threshold);
			hear2 = it.tone2_peak && (it.tone2_level > shadow_cfg.level_threshold);
			trk1  = advance_track(trk1, it.now_ms, hear1, shadow_cfg.tone1_min_ms);
			trk2  = advance_track(trk2, it.now_ms, hear2, shadow_cfg.tone2_min_ms);
		end
		// plain unsigned compare; a time equal to the cooldown end fires again
		if (!(it.now_ms < cooldown_end) && trk1.flag && trk2.flag) begin
			cooldown_end   = it.now_ms + shadow_cfg.hold_off_ms;
			r.detect_pulse = 1'b1;
		end
		r.tone1_on = trk1.flag;
		r.tone2_on = trk2.flag;
		return r;
	endfunction

	// ---------------------------------------------------------------- driver

	// Inputs change at the falling edge. A new item goes out only once the last one
	// was taken, so valid never drops while an item is on offer.
	always @(negedge clk) begin : driver
		tone_item_t nxt;
		if (arst_n) begin
			if (item_fire || !item_ch.valid) begin
				if (tone_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					nxt                 = tone_items.pop_front();
					item_ch.valid       <= 1'b1;
					item_ch.now_ms      <= nxt.now_ms;
					item_ch.tone1_peak  <= nxt.tone1_peak;
					item_ch.tone1_level <= nxt.tone1_level;
					item_ch.tone2_peak  <= nxt.tone2_peak;
					item_ch.tone2_level <= nxt.tone2_level;
					sent_cnt++;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
			result_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// ---------------------------------------------------------------- monitor

	// Sampled at the rising edge. Results are checked before the new item's
	// expectation is queued, so a stray result can never match it.
	always @(posedge clk) begin : monitor
		tone_flags_t got;
		tone_flags_t want;
		tone_item_t  seen;
		if (arst_n) begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("CHECK FAILED");
				$finish;
			end else begin
				if (result_ch.valid && result_ch.ready) begin
					got = {result_ch.detect_pulse, result_ch.tone1_on, result_ch.tone2_on,
						result_ch.holding, result_ch.cleared};
					if (predicted_flags.size() == 0) begin
						mismatches++;
						if (mismatches <= 10)
							$display("unexpected result transaction: %b", got);
					end else begin
						want = predicted_flags.pop_front();
						if (got !== want) begin
							mismatches++;
							if (mismatches <= 10)
								$display("result mismatch (pulse,t1,t2,hold,clr): expected %b got %b",
									want, got);
						end
					end
				end
				item_fire = item_ch.valid && item_ch.ready;
				if (item_fire) begin
					seen = {item_ch.now_ms, item_ch.tone1_peak, item_ch.tone1_level,
						item_ch.tone2_peak, item_ch.tone2_level};
					predicted_flags.push_back(detect_step(seen));
				end
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic push_item(input logic [tttd_pkg::TIME_W-1:0] now, input logic p1,
		input logic [tttd_pkg::LEVEL_W-1:0] l1, input logic p2,
		input logic [tttd_pkg::LEVEL_W-1:0] l2);
		tone_item_t it;
		it = {now, p1, l1, p2, l2};
		tone_items.push_back(it);
	endtask

	// Waits until nothing is on offer or expected, then lets the pipeline drain.
	task automatic settle();
		while (tone_items.size() != 0 || item_ch.valid || predicted_flags.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write; the predictor copy follows once the transaction is done.
	task automatic write_reg(input logic [tttd_pkg::CIDX_W-1:0] idx,
		input logic [tttd_pkg::CDATA_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			tttd_pkg::REG_LEVEL_THRESHOLD:
				shadow_cfg.level_threshold = val[tttd_pkg::LEVEL_W-1:0];
			tttd_pkg::REG_TONE1_MIN_MS:  shadow_cfg.tone1_min_ms  = val[tttd_pkg::MS_W-1:0];
			tttd_pkg::REG_TONE2_MIN_MS:  shadow_cfg.tone2_min_ms  = val[tttd_pkg::MS_W-1:0];
			tttd_pkg::REG_GAP_WINDOW_MS: shadow_cfg.gap_window_ms = val[tttd_pkg::MS_W-1:0];
			tttd_pkg::REG_HOLD_OFF_MS:   shadow_cfg.hold_off_ms   = val[tttd_pkg::MS_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// 16-bit registers get random upper data bits, which must be dropped
	function automatic logic [tttd_pkg::CDATA_W-1:0] ms_data(input int unsigned hi);
		return tttd_pkg::CDATA_W'(($urandom & 32'h000F_0000) | $urandom_range(0, hi));
	endfunction

	task automatic setup_phase(input cfg_style_t style);
		case (style)
			CFG_ZERO: begin
				write_reg(tttd_pkg::REG_LEVEL_THRESHOLD, '0);
				write_reg(tttd_pkg::REG_TONE1_MIN_MS, '0);
				write_reg(tttd_pkg::REG_TONE2_MIN_MS, '0);
				write_reg(tttd_pkg::REG_GAP_WINDOW_MS, '0);
				write_reg(tttd_pkg::REG_HOLD_OFF_MS, '0);
			end
			CFG_MAX: begin
				write_reg(tttd_pkg::REG_LEVEL_THRESHOLD, '1);
				write_reg(tttd_pkg::REG_TONE1_MIN_MS, '1);
				write_reg(tttd_pkg::REG_TONE2_MIN_MS, '1);
				write_reg(tttd_pkg::REG_GAP_WINDOW_MS, '1);
				write_reg(tttd_pkg::REG_HOLD_OFF_MS, '1);
			end
			CFG_SHORT: begin
				write_reg(tttd_pkg::REG_LEVEL_THRESHOLD, tttd_pkg::CDATA_W'($urandom));
				write_reg(tttd_pkg::REG_TONE1_MIN_MS, ms_data(1500));
				write_reg(tttd_pkg::REG_TONE2_MIN_MS, ms_data(1500));
				write_reg(tttd_pkg::REG_GAP_WINDOW_MS, ms_data(3000));
				write_reg(tttd_pkg::REG_HOLD_OFF_MS, ms_data(3000));
			end
			default: begin
				write_reg(tttd_pkg::REG_LEVEL_THRESHOLD, tttd_pkg::CDATA_W'($urandom));
				write_reg(tttd_pkg::REG_TONE1_MIN_MS, ms_data(20000));
				write_reg(tttd_pkg::REG_TONE2_MIN_MS, ms_data(20000));
				write_reg(tttd_pkg::REG_GAP_WINDOW_MS, ms_data(40000));
				write_reg(tttd_pkg::REG_HOLD_OFF_MS, ms_data(65535));
			end
		endcase
		write_reg(tttd_pkg::CIDX_W'($urandom_range(REG_NONE_FIRST, (1 << tttd_pkg::CIDX_W) - 1)),
			tttd_pkg::CDATA_W'($urandom));
	endtask

	// {peak, level} of one tone. A present tone sits above the threshold, often
	// just above; an absent one has its peak low or its level at most the threshold.
	function automatic logic [tttd_pkg::LEVEL_W:0] tone_sample(input bit present);
		logic [tttd_pkg::LEVEL_W-1:0] thr;
		int unsigned span;
		thr = shadow_cfg.level_threshold;
		if (present && thr != '1) begin
			span = 20'hFFFFF - thr - 1;
			if ($urandom_range(0, 3) == 0)
				return {1'b1, thr + 20'd1};
			return {1'b1, tttd_pkg::LEVEL_W'(thr + 1 + $urandom_range(0, span))};
		end
		if ($urandom_range(0, 1) == 0)
			return {1'b0, tttd_pkg::LEVEL_W'($urandom)};
		return {1'b1, tttd_pkg::LEVEL_W'($urandom_range(0, thr))};
	endfunction

	// how often a tone is present within one burst
	function automatic int unsigned tone_odds();
		case ($urandom_range(0, 2))
			0: return 95;
			1: return 60;
			default: return 10;
		endcase
	endfunction

	// A burst: rising timestamps with steps scaled to the current registers, so
	// tracks start, go active, fire, hold, clear and time out.
	task automatic add_burst(input int len);
		logic [tttd_pkg::TIME_W-1:0] now;
		int unsigned scale;
		int unsigned step_max;
		int unsigned odds1;
		int unsigned odds2;
		tone_item_t it;
		scale = shadow_cfg.tone1_min_ms;
		if (shadow_cfg.tone2_min_ms > scale) scale = shadow_cfg.tone2_min_ms;
		if (shadow_cfg.gap_window_ms > scale) scale = shadow_cfg.gap_window_ms;
		if (shadow_cfg.hold_off_ms > scale) scale = shadow_cfg.hold_off_ms;
		step_max = scale / 4 + 2;
		case ($urandom_range(0, 9))
			0, 1:    now = 32'hFFFF_FFFF - $urandom_range(0, scale * 4 + 16);  // across the wrap
			2:       now = '0;
			default: now = $urandom;
		endcase
		odds1 = tone_odds();
		odds2 = tone_odds();
		for (int i = 0; i < len; i++) begin
			it.now_ms = now;
			{it.tone1_peak, it.tone1_level} = tone_sample($urandom_range(0, 99) < odds1);
			{it.tone2_peak, it.tone2_level} = tone_sample($urandom_range(0, 99) < odds2);
			tone_items.push_back(it);
			now = now + $urandom_range(0, step_max);
		end
	endtask

	initial begin : stimulus
		cfg_style_t phase_plan[8];
		int added;
		int len;
		phase_plan = '{CFG_ZERO, CFG_SHORT, CFG_MAX, CFG_SHORT, CFG_LONG, CFG_SHORT,
			CFG_LONG, CFG_SHORT};

		arst_n              = 1'b0;
		item_ch.valid       = 1'b0;
		item_ch.now_ms      = '0;
		item_ch.tone1_peak  = 1'b0;
		item_ch.tone1_level = '0;
		item_ch.tone2_peak  = 1'b0;
		item_ch.tone2_level = '0;
		result_ch.ready     = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = '0;
		cfg_ch.data         = '0;

		shadow_cfg.level_threshold = tttd_pkg::RST_LEVEL_THRESHOLD;
		shadow_cfg.tone1_min_ms    = tttd_pkg::RST_TONE1_MIN_MS;
		shadow_cfg.tone2_min_ms    = tttd_pkg::RST_TONE2_MIN_MS;
		shadow_cfg.gap_window_ms   = tttd_pkg::RST_GAP_WINDOW_MS;
		shadow_cfg.hold_off_ms     = tttd_pkg::RST_HOLD_OFF_MS;
		trk1         = '0;
		trk2         = '0;
		cooldown_end = '0;

		// directed part, reset register values
		// tone starting at time zero stays unstarted and is restarted on the next item
		push_item(32'd0, 1'b1, 20'd5001, 1'b0, 20'hFFFFF);
		push_item(32'd10, 1'b1, 20'd5001, 1'b0, 20'd0);
		// level equal to the threshold is absent; exactly at the window no reset
		push_item(32'd20, 1'b1, 20'd5000, 1'b0, 20'd5001);
		push_item(32'd2010, 1'b0, 20'hFFFFF, 1'b0, 20'd0);
		push_item(32'd2011, 1'b0, 20'd0, 1'b0, 20'd0);
		// tracks started before the timestamp wraps, both active after it
		push_item(32'hFFFF_FF00, 1'b1, 20'hFFFFF, 1'b1, 20'hFFFFF);
		push_item(32'h0000_0100, 1'b1, 20'd5001, 1'b1, 20'd5001);
		push_item(32'h0000_01C0, 1'b1, 20'd5001, 1'b1, 20'd5001);
		// timestamp equal to the cooldown end: hold and fire again
		push_item(32'd2448, 1'b0, 20'd0, 1'b0, 20'd0);
		push_item(32'd3000, 1'b1, 20'd5001, 1'b1, 20'd5001);
		push_item(32'd4449, 1'b1, 20'd5001, 1'b1, 20'd5001);
		push_item(32'd5000, 1'b1, 20'd5001, 1'b1, 20'd5001);
		push_item(32'd5600, 1'b1, 20'd5001, 1'b0, 20'd0);
		push_item(32'd5700, 1'b1, 20'd5001, 1'b1, 20'd5001);
		push_item(32'hFFFF_FFFF, 1'b1, 20'd0, 1'b1, 20'd0);
		push_item(32'd0, 1'b0, 20'd0, 1'b0, 20'd0);
		// cooldown end wraps past 2^32 and so reads as already over
		push_item(32'hFFFF_F800, 1'b1, 20'd6000, 1'b1, 20'd6000);
		push_item(32'hFFFF_FC00, 1'b1, 20'd6000, 1'b1, 20'd6000);
		push_item(32'hFFFF_FD00, 1'b0, 20'd0, 1'b0, 20'd0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		settle();
		foreach (phase_plan[p]) begin
			setup_phase(phase_plan[p]);
			added = 0;
			while (added < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 15) begin
					// noise: any field value, timestamps anywhere
					push_item($urandom, 1'($urandom), tttd_pkg::LEVEL_W'($urandom),
						1'($urandom), tttd_pkg::LEVEL_W'($urandom));
					added++;
				end else begin
					len = $urandom_range(8, 30);
					add_burst(len);
					added += len;
				end
			end
			settle();
		end

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
